/* design/utf16_to_utf8_transcoder_assert.svh */
// Assertion macros for the UTF-16 to UTF-8 transcoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define U2U_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define U2U_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define U2U_ASSERT_SAME(lbl, ante, cons, msg)
`define U2U_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/u2u_pkg.sv */
// Types, constants and encode functions for the UTF-16 to UTF-8 transcoder.
// No dependencies.
`timescale 1ns / 1ps

package u2u_pkg;

    localparam logic [15:0] HIGH_BASE = 16'hD800;
    localparam logic [15:0] LOW_BASE  = 16'hDC00;
    localparam logic [15:0] SURR_END  = 16'hE000;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam logic [7:0] LEAD2 = 8'b110_00000;
    localparam logic [7:0] LEAD3 = 8'b1110_0000;
    localparam logic [7:0] LEAD4 = 8'b11110_000;
    localparam logic [7:0] CONT  = 8'b10_000000;

    localparam int unsigned RUN_MAX = 6;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } out_item_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] data;
        logic [2:0]              cnt;
        logic                    last;
    } run_t;

    typedef struct packed {
        logic       valid;
        logic [9:0] offset;
    } hold_t;

    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      len;
    } bmp_enc_t;

    // One to three bytes for a value below 0x10000, first byte in data[0].
    function automatic bmp_enc_t enc_bmp(input logic [15:0] u);
        bmp_enc_t e;
        e = '0;
        if (u[15:7] == 9'd0)
        begin
            e.data[0] = {1'b0, u[6:0]};
            e.len     = 2'd1;
        end
        else if (u[15:11] == 5'd0)
        begin
            e.data[0] = LEAD2 | {3'b000, u[10:6]};
            e.data[1] = CONT | {2'b00, u[5:0]};
            e.len     = 2'd2;
        end
        else
        begin
            e.data[0] = LEAD3 | {4'b0000, u[15:12]};
            e.data[1] = CONT | {2'b00, u[11:6]};
            e.data[2] = CONT | {2'b00, u[5:0]};
            e.len     = 2'd3;
        end
        return e;
    endfunction

    // Four bytes for a surrogate pair.
    function automatic logic [3:0][7:0] enc_pair(input logic [9:0] hi, input logic [9:0] lo);
        logic [20:0]     cp;
        logic [3:0][7:0] b;
        cp   = {1'b0, hi, lo} + SUPP_BASE;
        b[0] = LEAD4 | {5'b00000, cp[20:18]};
        b[1] = CONT | {2'b00, cp[17:12]};
        b[2] = CONT | {2'b00, cp[11:6]};
        b[3] = CONT | {2'b00, cp[5:0]};
        return b;
    endfunction

endpackage

/* design/utf16_to_utf8_transcoder.sv */
// Top level of the UTF-16 to UTF-8 transcoder.
// Depends on u2u_pkg, u2u_in_stage, u2u_encode, u2u_serial and the assert header.
//
//   channel   valid        stall        request
//   unit      unit_valid   unit_stall   unit_req  (code_unit, end_of_string)
//   byte      byte_valid   byte_stall   byte_req  (out_byte, run_end, string_end)
//
// The output sends one byte per cycle while byte_stall is low.
// A unit's first byte passes through the input, run and output registers in that order.
// A held high surrogate causes no byte and frees the input.
// rst_n clears the valid flags of the input, run and output registers and the surrogate hold.
// byte_stall freezes the output register; input stalls when the run is busy and a unit waits.
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_assert.svh"

module utf16_to_utf8_transcoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               unit_valid,
    output logic               unit_stall,
    input  u2u_pkg::in_item_t  unit_req,
    output logic               byte_valid,
    input  logic               byte_stall,
    output u2u_pkg::out_item_t byte_req
);

    logic              stage_valid;
    u2u_pkg::in_item_t stage_item;
    u2u_pkg::run_t     run;
    u2u_pkg::hold_t    hold;
    logic              ser_ready;
    logic              take;
    logic              load;

    assign take = stage_valid && ((run.cnt == 3'd0) || ser_ready);
    assign load = take && (run.cnt != 3'd0);

    u2u_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_valid  (unit_valid),
        .unit_stall  (unit_stall),
        .unit_req    (unit_req),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    u2u_encode u_encode
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (stage_item),
        .run   (run),
        .hold  (hold)
    );

    u2u_serial u_serial
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .run        (run),
        .ready      (ser_ready),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_req   (byte_req)
    );

    `U2U_ASSERT_NEXT(a_eos_clears_hold, take && stage_item.end_of_string, !hold.valid,
        "surrogate hold survived end of string")
    `U2U_ASSERT_NEXT(a_run_contiguous, byte_valid && !byte_stall && !byte_req.run_end,
        byte_valid, "gap inside a byte run")
    `U2U_ASSERT_SAME(a_stall_needs_item, unit_stall, stage_valid,
        "input stalled with empty input register")

endmodule

/* design/u2u_in_stage.sv */
// Input register for code-unit requests.
// Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              unit_valid,
    output logic              unit_stall,
    input  u2u_pkg::in_item_t unit_req,
    input  logic              take,
    output logic              stage_valid,
    output u2u_pkg::in_item_t stage_item
);

    logic              valid_reg;
    logic              valid_next;
    u2u_pkg::in_item_t item_reg;
    logic              accept;

    assign unit_stall  = valid_reg && !take;
    assign accept      = unit_valid && !unit_stall;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= unit_req;
        end
    end

endmodule

/* design/u2u_encode.sv */
// Surrogate hold state and byte encoding of one code unit.
// Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_encode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  u2u_pkg::in_item_t item,
    output u2u_pkg::run_t     run,
    output u2u_pkg::hold_t    hold
);

    u2u_pkg::hold_t    hold_reg;
    u2u_pkg::hold_t    hold_next;
    logic              is_high;
    logic              is_low;
    logic              last;
    logic              emit_new;
    u2u_pkg::bmp_enc_t enc_unit;
    u2u_pkg::bmp_enc_t enc_held;

    assign last     = item.end_of_string;
    assign is_high  = (item.code_unit >= u2u_pkg::HIGH_BASE)
                   && (item.code_unit < u2u_pkg::LOW_BASE);
    assign is_low   = (item.code_unit >= u2u_pkg::LOW_BASE)
                   && (item.code_unit < u2u_pkg::SURR_END);
    assign emit_new = !(is_high && !last);
    assign enc_unit = u2u_pkg::enc_bmp(item.code_unit);
    assign enc_held = u2u_pkg::enc_bmp(u2u_pkg::HIGH_BASE | {6'd0, hold_reg.offset});
    assign hold     = hold_reg;

    always_comb
    begin
        run      = '0;
        run.last = last;
        if (hold_reg.valid && is_low)
        begin
            run.data[3:0] = u2u_pkg::enc_pair(hold_reg.offset, item.code_unit[9:0]);
            run.cnt       = 3'd4;
        end
        else if (hold_reg.valid)
        begin
            run.data[2:0] = enc_held.data;
            run.cnt       = 3'd3;
            if (emit_new)
            begin
                run.data[5:3] = enc_unit.data;
                run.cnt       = 3'd3 + {1'b0, enc_unit.len};
            end
        end
        else if (emit_new)
        begin
            run.data[2:0] = enc_unit.data;
            run.cnt       = {1'b0, enc_unit.len};
        end
    end

    always_comb
    begin
        hold_next = hold_reg;
        if (take)
        begin
            if (last)
            begin
                hold_next = '0;
            end
            else if (is_high && !(hold_reg.valid && is_low))
            begin
                hold_next.valid  = 1'b1;
                hold_next.offset = item.code_unit[9:0];
            end
            else
            begin
                hold_next.valid = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

endmodule

/* design/u2u_serial.sv */
// Run register and output register; sends a run one byte per cycle while byte_stall is low.
// Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_serial
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  u2u_pkg::run_t      run,
    output logic               ready,
    output logic               byte_valid,
    input  logic               byte_stall,
    output u2u_pkg::out_item_t byte_req
);

    logic               run_valid_reg;
    logic               run_valid_next;
    logic [2:0]         run_idx_reg;
    logic [2:0]         run_idx_next;
    u2u_pkg::run_t      run_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    u2u_pkg::out_item_t out_item_reg;
    logic               out_free;
    logic               emit;
    logic               final_byte;

    assign out_free   = !out_valid_reg || !byte_stall;
    assign emit       = run_valid_reg && out_free;
    assign final_byte = (run_idx_reg == (run_reg.cnt - 3'd1));
    assign ready      = !run_valid_reg || (emit && final_byte);
    assign byte_valid = out_valid_reg;
    assign byte_req   = out_item_reg;

    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        if (load)
        begin
            run_valid_next = 1'b1;
            run_idx_next   = 3'd0;
        end
        else if (emit && final_byte)
        begin
            run_valid_next = 1'b0;
        end
        else if (emit)
        begin
            run_idx_next = run_idx_reg + 3'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            run_idx_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            run_idx_reg   <= run_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= run;
        end
        if (emit)
        begin
            out_item_reg.out_byte   <= run_reg.data[run_idx_reg];
            out_item_reg.run_end    <= final_byte;
            out_item_reg.string_end <= final_byte && run_reg.last;
        end
    end

endmodule
